/* rtl/core/rayobb_pkg.sv */
// ----------------------------------------------------------------------------
// Ray / oriented box slab test: shared package
// Widths, register indexes, reset values and the structs passed between stages.
// ----------------------------------------------------------------------------
package rayobb_pkg;

    // Field and register widths.
    localparam int FLD_W  = 20;
    localparam int REG_W  = 3 * FLD_W;
    localparam int THR_W  = 18;
    localparam int CFG_IW = 3;

    // Arithmetic widths.
    localparam int DLT_W  = FLD_W + 1;       // center - origin
    localparam int PE_W   = FLD_W + DLT_W;   // axis * delta
    localparam int PF_W   = 2 * FLD_W;       // axis * dir
    localparam int E_W    = PE_W + 2;        // sum of three
    localparam int F_W    = PF_W + 2;
    localparam int HSH    = 18;              // Q10.10 to Q.28
    localparam int SUM_W  = E_W + 1;         // e +/- h
    localparam int NUM_W  = 42;              // numerator magnitude
    localparam int DEN_W  = 40;              // denominator magnitude
    localparam int FRAC_SH = 24;             // quotient scale
    localparam int SAT_SH = 38;              // integer quotient limit 2^38
    localparam int QUO_W  = 62;              // quotient bits below the cap
    localparam int T_W    = 63;              // signed slab distance
    localparam int OUT_W  = 32;

    localparam logic signed [T_W-1:0] T_LIM = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] D_MAX = T_W'(64'sh7FFF_FFFF);
    localparam logic signed [T_W-1:0] D_MIN = -T_W'(64'sh8000_0000);

    // Register indexes.
    localparam logic [CFG_IW-1:0] REG_CENTER = 3'd0;
    localparam logic [CFG_IW-1:0] REG_HALF   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_AXIS0  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_AXIS1  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_AXIS2  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_THR    = 3'd5;

    // Reset values.
    localparam logic [REG_W-1:0] RST_AXIS0 = 60'd262144;
    localparam logic [REG_W-1:0] RST_AXIS1 = 60'd274877906944;
    localparam logic [REG_W-1:0] RST_AXIS2 = 60'd288230376151711744;
    localparam logic [THR_W-1:0] RST_THR   = 18'd1;

    // Per-axis flags that ride alongside the dividers.
    typedef struct packed {
        logic neg1;
        logic neg2;
        logic sat1;
        logic sat2;
        logic par;
    } t_axis_side;

    typedef struct packed {
        logic               vld;
        logic               pmiss;
        t_axis_side [2:0]   ax;
    } t_side;

endpackage

/* rtl/core/ray_obb_slab_intersection.sv */
// Pipeline: 4 projection stages, 62 divider stages and 3 resolve stages
// including the output register.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while the output register is full and stalled.
// Reset: synchronous, active low; clears all valid bits and loads the box
// registers with their defaults (unit axes, zero center and extents).
// ----------------------------------------------------------------------------
// Ray / oriented box slab intersection
// Tests a ray against an oriented box held in registers and returns hit and
// the Q16.16 hit distance.
// ----------------------------------------------------------------------------
module ray_obb_slab_intersection (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [rayobb_pkg::FLD_W-1:0]     i_origin_x,
    input  logic signed [rayobb_pkg::FLD_W-1:0]     i_origin_y,
    input  logic signed [rayobb_pkg::FLD_W-1:0]     i_origin_z,
    input  logic signed [rayobb_pkg::FLD_W-1:0]     i_dir_x,
    input  logic signed [rayobb_pkg::FLD_W-1:0]     i_dir_y,
    input  logic signed [rayobb_pkg::FLD_W-1:0]     i_dir_z,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_hit,
    output logic signed [rayobb_pkg::OUT_W-1:0]     o_hit_distance,
    input  logic                                    i_cfg_wr_en,
    input  logic [rayobb_pkg::CFG_IW-1:0]           i_cfg_idx,
    input  logic [rayobb_pkg::REG_W-1:0]            i_cfg_data
);
    localparam int DIV_STEPS = rayobb_pkg::QUO_W;

    logic [rayobb_pkg::REG_W-1:0]       r_center;
    logic [rayobb_pkg::REG_W-1:0]       r_half;
    logic [2:0][rayobb_pkg::REG_W-1:0]  r_axes;
    logic [rayobb_pkg::THR_W-1:0]       r_thr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_half   <= '0;
            r_axes   <= {rayobb_pkg::RST_AXIS2, rayobb_pkg::RST_AXIS1, rayobb_pkg::RST_AXIS0};
            r_thr    <= rayobb_pkg::RST_THR;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                rayobb_pkg::REG_CENTER: r_center  <= i_cfg_data;
                rayobb_pkg::REG_HALF:   r_half    <= i_cfg_data;
                rayobb_pkg::REG_AXIS0:  r_axes[0] <= i_cfg_data;
                rayobb_pkg::REG_AXIS1:  r_axes[1] <= i_cfg_data;
                rayobb_pkg::REG_AXIS2:  r_axes[2] <= i_cfg_data;
                rayobb_pkg::REG_THR:    r_thr     <= i_cfg_data[rayobb_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves unless a finished result is held by the consumer.
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // Projection stages.
    logic [5:0][rayobb_pkg::NUM_W-1:0]  w_num;
    logic [2:0][rayobb_pkg::DEN_W-1:0]  w_den;
    rayobb_pkg::t_side                  w_side;

    rayobb_proj u_proj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (i_valid),
        .i_origin ({i_origin_z, i_origin_y, i_origin_x}),
        .i_dir    ({i_dir_z, i_dir_y, i_dir_x}),
        .i_center (r_center),
        .i_half   (r_half),
        .i_axes   (r_axes),
        .i_thr    (r_thr),
        .o_num    (w_num),
        .o_den    (w_den),
        .o_side   (w_side)
    );

    // Six dividers: entry and exit numerator for each axis.
    logic [5:0][rayobb_pkg::QUO_W-1:0] w_quot;

    for (genvar j = 0; j < 6; j++) begin : g_div
        rayobb_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_num  (w_num[j]),
            .i_den  (w_den[j/2]),
            .o_quot (w_quot[j])
        );
    end

    // Flags and valid travel beside the dividers.
    rayobb_pkg::t_side r_side [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_side[s].vld <= 1'b0;
            end
        end else if (w_adv) begin
            r_side[0] <= w_side;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Interval resolve and output register.
    rayobb_resolve u_resolve (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_side         (r_side[DIV_STEPS-1]),
        .i_quot         (w_quot),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_hit_distance (o_hit_distance)
    );

    // A miss always reports a zero distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_hit_distance == '0)
        else $error("miss with nonzero distance");

    // A hit never lies behind the ray origin.
    a_hit_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_hit_distance[rayobb_pkg::OUT_W-1])
        else $error("negative hit distance");

    // A held result stops the whole pipeline, input side included.
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("pipeline advanced under output stall");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid result right after reset");

endmodule

/* rtl/core/rayobb_proj.sv */
// ----------------------------------------------------------------------------
// Ray / oriented box: projection stages
// Four register stages: center offset, axis products, dot sums, then slab
// numerators, magnitudes and the parallel-axis test.
// ----------------------------------------------------------------------------
module rayobb_proj (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  logic [rayobb_pkg::REG_W-1:0]                i_origin,
    input  logic [rayobb_pkg::REG_W-1:0]                i_dir,
    input  logic [rayobb_pkg::REG_W-1:0]                i_center,
    input  logic [rayobb_pkg::REG_W-1:0]                i_half,
    input  logic [2:0][rayobb_pkg::REG_W-1:0]           i_axes,
    input  logic [rayobb_pkg::THR_W-1:0]                i_thr,
    output logic [5:0][rayobb_pkg::NUM_W-1:0]           o_num,
    output logic [2:0][rayobb_pkg::DEN_W-1:0]           o_den,
    output rayobb_pkg::t_side                           o_side
);
    localparam int FW    = rayobb_pkg::FLD_W;
    localparam int DLT_W = rayobb_pkg::DLT_W;
    localparam int PE_W  = rayobb_pkg::PE_W;
    localparam int PF_W  = rayobb_pkg::PF_W;
    localparam int E_W   = rayobb_pkg::E_W;
    localparam int F_W   = rayobb_pkg::F_W;
    localparam int SUM_W = rayobb_pkg::SUM_W;
    localparam int NUM_W = rayobb_pkg::NUM_W;
    localparam int DEN_W = rayobb_pkg::DEN_W;

    logic [3:0] r_vld;

    logic signed [rayobb_pkg::DLT_W-1:0] r_dlt [3];
    logic signed [FW-1:0]                r_dir [3];
    logic signed [rayobb_pkg::PE_W-1:0]  r_pe  [3][3];
    logic signed [rayobb_pkg::PF_W-1:0]  r_pf  [3][3];
    logic signed [rayobb_pkg::E_W-1:0]   r_e   [3];
    logic signed [rayobb_pkg::F_W-1:0]   r_f   [3];

    logic [5:0][rayobb_pkg::NUM_W-1:0]   r_num;
    logic [2:0][rayobb_pkg::DEN_W-1:0]   r_den;
    rayobb_pkg::t_axis_side [2:0]        r_ax;
    logic                                r_pmiss;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // Stage 1: center offset and direction.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_dlt[k] <= DLT_W'($signed(i_center[k*FW +: FW]))
                          - DLT_W'($signed(i_origin[k*FW +: FW]));
                r_dir[k] <= $signed(i_dir[k*FW +: FW]);
            end
        end
    end

    // Stage 2: the eighteen products of the axes with offset and direction.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pe[i][k] <= PE_W'($signed(i_axes[i][k*FW +: FW]) * r_dlt[k]);
                    r_pf[i][k] <= PF_W'($signed(i_axes[i][k*FW +: FW]) * r_dir[k]);
                end
            end
        end
    end

    // Stage 3: dot products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e[i] <= E_W'(r_pe[i][0]) + E_W'(r_pe[i][1]) + E_W'(r_pe[i][2]);
                r_f[i] <= F_W'(r_pf[i][0]) + F_W'(r_pf[i][1]) + F_W'(r_pf[i][2]);
            end
        end
    end

    // Stage 4: numerators, magnitudes, signs, cap detection and parallel test.
    logic [5:0][rayobb_pkg::NUM_W-1:0]  n_num;
    logic [2:0][rayobb_pkg::DEN_W-1:0]  n_den;
    rayobb_pkg::t_axis_side [2:0]       n_ax;
    logic                               n_pmiss;

    always_comb begin
        logic signed [rayobb_pkg::SUM_W-1:0] w_e;
        logic signed [rayobb_pkg::SUM_W-1:0] w_h;
        logic signed [rayobb_pkg::SUM_W-1:0] w_n1;
        logic signed [rayobb_pkg::SUM_W-1:0] w_n2;
        logic signed [rayobb_pkg::F_W-1:0]   w_f;
        logic [rayobb_pkg::DEN_W-1:0]        w_thr;
        w_thr   = DEN_W'({i_thr, rayobb_pkg::HSH'(0)});
        n_pmiss = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_e  = SUM_W'(r_e[i]);
            w_h  = $signed(SUM_W'({i_half[i*FW +: FW], rayobb_pkg::HSH'(0)}));
            w_n1 = w_e + w_h;
            w_n2 = w_e - w_h;
            w_f  = r_f[i];
            n_num[2*i]   = NUM_W'(w_n1[SUM_W-1] ? -w_n1 : w_n1);
            n_num[2*i+1] = NUM_W'(w_n2[SUM_W-1] ? -w_n2 : w_n2);
            n_den[i]     = DEN_W'(w_f[F_W-1] ? -w_f : w_f);
            n_ax[i].neg1 = w_n1[SUM_W-1] ^ w_f[F_W-1];
            n_ax[i].neg2 = w_n2[SUM_W-1] ^ w_f[F_W-1];
            n_ax[i].sat1 = DEN_W'(n_num[2*i]   >> rayobb_pkg::SAT_SH) >= n_den[i];
            n_ax[i].sat2 = DEN_W'(n_num[2*i+1] >> rayobb_pkg::SAT_SH) >= n_den[i];
            n_ax[i].par  = n_den[i] <= w_thr;
            if (n_ax[i].par && (w_e > w_h || w_e < -w_h)) begin
                n_pmiss = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= n_num;
            r_den   <= n_den;
            r_ax    <= n_ax;
            r_pmiss <= n_pmiss;
        end
    end

    assign o_num        = r_num;
    assign o_den        = r_den;
    assign o_side.vld   = r_vld[3];
    assign o_side.pmiss = r_pmiss;
    assign o_side.ax    = r_ax;

endmodule

/* rtl/core/rayobb_div.sv */
// ----------------------------------------------------------------------------
// Ray / oriented box: pipelined slab divider
// Restoring division of num * 2^24 by den, one quotient bit per stage,
// producing the low 62 bits. Capped quotients are flagged upstream.
// ----------------------------------------------------------------------------
module rayobb_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rayobb_pkg::NUM_W-1:0]    i_num,
    input  logic [rayobb_pkg::DEN_W-1:0]    i_den,
    output logic [rayobb_pkg::QUO_W-1:0]    o_quot
);
    localparam int STEPS = rayobb_pkg::QUO_W;
    localparam int DW    = rayobb_pkg::DEN_W;
    localparam int NW    = rayobb_pkg::NUM_W;

    logic [DW-1:0]    r_rem  [STEPS];
    logic [DW-1:0]    r_den  [STEPS];
    logic [NW-1:0]    r_num  [STEPS];
    logic [STEPS-1:0] r_quot [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam int BIT = STEPS - 1 - s;

        logic [DW-1:0]    w_rem_in;
        logic [DW-1:0]    w_den_in;
        logic [NW-1:0]    w_num_in;
        logic [STEPS-1:0] w_quot_in;
        logic             w_nbit;
        logic [DW:0]      w_trial;
        logic [DW-1:0]    n_rem;
        logic [STEPS-1:0] n_quot;

        // The first step starts from the numerator bits above the quotient range.
        if (s == 0) begin : g_first
            assign w_rem_in  = DW'(i_num >> rayobb_pkg::SAT_SH);
            assign w_den_in  = i_den;
            assign w_num_in  = i_num;
            assign w_quot_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_den_in  = r_den[s-1];
            assign w_num_in  = r_num[s-1];
            assign w_quot_in = r_quot[s-1];
        end

        // Next dividend bit; the scaled numerator has zeros in its low bits.
        if (BIT >= rayobb_pkg::FRAC_SH) begin : g_nbit
            assign w_nbit = w_num_in[BIT - rayobb_pkg::FRAC_SH];
        end else begin : g_zbit
            assign w_nbit = 1'b0;
        end

        // Trial subtract and quotient bit.
        always_comb begin
            w_trial = {w_rem_in, w_nbit};
            n_quot  = w_quot_in;
            if (w_trial >= {1'b0, w_den_in}) begin
                n_rem       = DW'(w_trial - {1'b0, w_den_in});
                n_quot[BIT] = 1'b1;
            end else begin
                n_rem       = DW'(w_trial);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_den[s]  <= w_den_in;
                r_num[s]  <= w_num_in;
                r_quot[s] <= n_quot;
            end
        end
    end

    assign o_quot = r_quot[STEPS-1];

endmodule

/* rtl/core/rayobb_resolve.sv */
// ----------------------------------------------------------------------------
// Ray / oriented box: interval resolve
// Three register stages: signed slab distances per axis, near/far interval
// and miss test, then distance choice with Q16.16 clamping into the output.
// ----------------------------------------------------------------------------
module rayobb_resolve (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  rayobb_pkg::t_side                       i_side,
    input  logic [5:0][rayobb_pkg::QUO_W-1:0]       i_quot,
    output logic                                    o_valid,
    output logic                                    o_hit,
    output logic signed [rayobb_pkg::OUT_W-1:0]     o_hit_distance
);
    localparam int TW = rayobb_pkg::T_W;

    logic [1:0] r_vld;
    logic       r_out_vld;

    logic signed [TW-1:0] r_lo [3];
    logic signed [TW-1:0] r_hi [3];
    logic                 r_pmiss;
    logic signed [TW-1:0] r_near;
    logic signed [TW-1:0] r_far;
    logic                 r_miss;
    logic                 r_hit;
    logic signed [rayobb_pkg::OUT_W-1:0] r_dist;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= {r_vld[0], i_side.vld};
            r_out_vld <= r_vld[1];
        end
    end

    // Stage 1: signed entry and exit distances per axis.
    logic signed [TW-1:0] n_lo [3];
    logic signed [TW-1:0] n_hi [3];

    always_comb begin
        logic signed [TW-1:0] w_m1;
        logic signed [TW-1:0] w_m2;
        logic signed [TW-1:0] w_t1;
        logic signed [TW-1:0] w_t2;
        for (int i = 0; i < 3; i++) begin
            w_m1 = i_side.ax[i].sat1 ? rayobb_pkg::T_LIM : $signed({1'b0, i_quot[2*i]});
            w_m2 = i_side.ax[i].sat2 ? rayobb_pkg::T_LIM : $signed({1'b0, i_quot[2*i+1]});
            w_t1 = i_side.ax[i].neg1 ? -w_m1 : w_m1;
            w_t2 = i_side.ax[i].neg2 ? -w_m2 : w_m2;
            if (i_side.ax[i].par) begin
                // A parallel axis leaves the interval alone.
                n_lo[i] = -rayobb_pkg::T_LIM;
                n_hi[i] = rayobb_pkg::T_LIM;
            end else if (w_t1 > w_t2) begin
                n_lo[i] = w_t2;
                n_hi[i] = w_t1;
            end else begin
                n_lo[i] = w_t1;
                n_hi[i] = w_t2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_pmiss <= i_side.pmiss;
        end
    end

    // Stage 2: near is the largest entry, far the smallest exit.
    logic signed [TW-1:0] n_near;
    logic signed [TW-1:0] n_far;

    always_comb begin
        n_near = r_lo[0];
        n_far  = r_hi[0];
        for (int i = 1; i < 3; i++) begin
            if (r_lo[i] > n_near) begin
                n_near = r_lo[i];
            end
            if (r_hi[i] < n_far) begin
                n_far = r_hi[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_near <= n_near;
            r_far  <= n_far;
            r_miss <= r_pmiss || (n_near > n_far) || n_far[TW-1];
        end
    end

    // Stage 3: pick the distance, clamp it, and load the output register.
    logic signed [TW-1:0]                n_d;
    logic signed [rayobb_pkg::OUT_W-1:0] n_dist;

    always_comb begin
        n_d = (r_near > 0) ? r_near : r_far;
        if (r_miss) begin
            n_dist = '0;
        end else if (n_d > rayobb_pkg::D_MAX) begin
            n_dist = rayobb_pkg::OUT_W'(rayobb_pkg::D_MAX);
        end else if (n_d < rayobb_pkg::D_MIN) begin
            n_dist = rayobb_pkg::OUT_W'(rayobb_pkg::D_MIN);
        end else begin
            n_dist = rayobb_pkg::OUT_W'(n_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit  <= !r_miss;
            r_dist <= n_dist;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_hit          = r_hit;
    assign o_hit_distance = r_dist;

endmodule
